// File: rtl/asm_tok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asm_tok_pkg
// Shared types and constants for the assembly source tokenizer.
// ----------------------------------------------------------------------------
package asm_tok_pkg;

    localparam int MAX_WORD_BYTES_DEF = 8;
    localparam int POSITION_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH        = 4;

    localparam int TEXT_W = 64;
    localparam int LENO_W = 4;
    localparam int POSO_W = 16;

    // character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    typedef enum logic [1:0] {
        KIND_WORD    = 2'd0,
        KIND_SYMBOL  = 2'd1,
        KIND_NEWLINE = 2'd2,
        KIND_ILLEGAL = 2'd3
    } t_kind;

    // one queue entry: an optional word and an optional one-byte token
    typedef struct packed {
        logic              has_word;
        logic [TEXT_W-1:0] word_text;
        logic [LENO_W-1:0] word_len;
        logic              word_ovf;
        logic [POSO_W-1:0] word_line;
        logic [POSO_W-1:0] word_col;
        logic              has_tok;
        t_kind             tok_kind;
        logic [7:0]        tok_char;
        logic [POSO_W-1:0] tok_line;
        logic [POSO_W-1:0] tok_col;
    } t_rec;

endpackage

// File: rtl/asm_tok_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asm_tok_front
// Takes one byte per beat, classifies it, tracks word and position state and
// pushes finished tokens into the queue.
// ----------------------------------------------------------------------------
module asm_tok_front #(
    parameter int MAX_WORD_BYTES = asm_tok_pkg::MAX_WORD_BYTES_DEF,
    parameter int POSITION_BITS  = asm_tok_pkg::POSITION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_char_in,
    input  logic              i_end_of_input,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output asm_tok_pkg::t_rec o_rec
);

    localparam int BUF_W = MAX_WORD_BYTES * 8;
    localparam int LEN_W = $clog2(MAX_WORD_BYTES + 1);

    typedef enum logic [6:0] {
        CLS_WORD    = 7'b0000001,
        CLS_SYMBOL  = 7'b0000010,
        CLS_SPACE   = 7'b0000100,
        CLS_NEWLINE = 7'b0001000,
        CLS_HASH    = 7'b0010000,
        CLS_CR      = 7'b0100000,
        CLS_ILLEGAL = 7'b1000000
    } t_cls;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        r = CLS_ILLEGAL;
        if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h30 && c <= 8'h39) || c == asm_tok_pkg::CH_UNDER ||
            c == asm_tok_pkg::CH_DOT || c == asm_tok_pkg::CH_COLON)
            r = CLS_WORD;
        else if (c == asm_tok_pkg::CH_LPAREN || c == asm_tok_pkg::CH_RPAREN ||
                 c == asm_tok_pkg::CH_DOLLAR || c == asm_tok_pkg::CH_COMMA ||
                 c == asm_tok_pkg::CH_STAR)
            r = CLS_SYMBOL;
        else if (c == asm_tok_pkg::CH_SPACE || c == asm_tok_pkg::CH_TAB)
            r = CLS_SPACE;
        else if (c == asm_tok_pkg::CH_NEWLINE)
            r = CLS_NEWLINE;
        else if (c == asm_tok_pkg::CH_HASH)
            r = CLS_HASH;
        else if (c == asm_tok_pkg::CH_CR)
            r = CLS_CR;
        return r;
    endfunction

    function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
        return (&v) ? v : v + POSITION_BITS'(1);
    endfunction

    logic [BUF_W-1:0]         r_buf, n_buf;
    logic [LEN_W-1:0]         r_len, n_len;
    logic                     r_ovf, n_ovf;
    logic [POSITION_BITS-1:0] r_wline, n_wline, r_wcol, n_wcol;
    logic [POSITION_BITS-1:0] r_line, n_line, r_col, n_col;
    logic                     r_comment, n_comment;
    logic                     r_halted, n_halted;

    logic              accept;
    t_cls              cls;
    asm_tok_pkg::t_rec rec;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign cls     = classify(i_char_in);

    always_comb begin
        n_buf     = r_buf;
        n_len     = r_len;
        n_ovf     = r_ovf;
        n_wline   = r_wline;
        n_wcol    = r_wcol;
        n_line    = r_line;
        n_col     = r_col;
        n_comment = r_comment;
        n_halted  = r_halted;

        rec           = '0;
        rec.word_text = asm_tok_pkg::TEXT_W'(r_buf);
        rec.word_len  = asm_tok_pkg::LENO_W'(r_len);
        rec.word_ovf  = r_ovf;
        rec.word_line = asm_tok_pkg::POSO_W'(r_wline);
        rec.word_col  = asm_tok_pkg::POSO_W'(r_wcol);
        rec.tok_kind  = asm_tok_pkg::KIND_SYMBOL;
        rec.tok_char  = i_char_in;
        rec.tok_line  = asm_tok_pkg::POSO_W'(r_line);
        rec.tok_col   = asm_tok_pkg::POSO_W'(r_col);

        if (i_end_of_input) begin
            rec.has_word = !r_halted && (r_len != '0);
            n_line    = POSITION_BITS'(1);
            n_col     = POSITION_BITS'(1);
            n_comment = 1'b0;
            n_halted  = 1'b0;
            n_buf     = '0;
            n_len     = '0;
            n_ovf     = 1'b0;
            n_wline   = POSITION_BITS'(1);
            n_wcol    = POSITION_BITS'(1);
        end else if (r_halted) begin
            // drop everything until end of input
        end else if (cls == CLS_NEWLINE) begin
            rec.has_word = (r_len != '0);
            rec.has_tok  = 1'b1;
            rec.tok_kind = asm_tok_pkg::KIND_NEWLINE;
            n_line    = pos_inc(r_line);
            n_col     = POSITION_BITS'(1);
            n_comment = 1'b0;
            n_buf     = '0;
            n_len     = '0;
            n_ovf     = 1'b0;
            n_wline   = pos_inc(r_line);
            n_wcol    = POSITION_BITS'(1);
        end else if (r_comment) begin
            n_col = pos_inc(r_col);
        end else begin
            unique case (cls)
                CLS_HASH: begin
                    // a pending word stays pending until the newline or end of input
                    n_comment = 1'b1;
                    n_col     = pos_inc(r_col);
                end
                CLS_SYMBOL: begin
                    rec.has_word = (r_len != '0);
                    rec.has_tok  = 1'b1;
                    n_col   = pos_inc(r_col);
                    n_buf   = '0;
                    n_len   = '0;
                    n_ovf   = 1'b0;
                    n_wline = r_line;
                    n_wcol  = pos_inc(r_col);
                end
                CLS_SPACE: begin
                    rec.has_word = (r_len != '0);
                    n_col   = pos_inc(r_col);
                    n_buf   = '0;
                    n_len   = '0;
                    n_ovf   = 1'b0;
                    n_wline = r_line;
                    n_wcol  = pos_inc(r_col);
                end
                CLS_WORD: begin
                    if (r_len < LEN_W'(MAX_WORD_BYTES)) begin
                        for (int b = 0; b < MAX_WORD_BYTES; b++) begin
                            if (r_len == LEN_W'(b))
                                n_buf[b*8 +: 8] = i_char_in;
                        end
                        n_len = r_len + LEN_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_col = pos_inc(r_col);
                end
                CLS_ILLEGAL: begin
                    rec.has_tok  = 1'b1;
                    rec.tok_kind = asm_tok_pkg::KIND_ILLEGAL;
                    n_halted = 1'b1;
                    n_buf    = '0;
                    n_len    = '0;
                    n_ovf    = 1'b0;
                    n_wline  = r_line;
                    n_wcol   = r_col;
                end
                CLS_CR, CLS_NEWLINE: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_push = accept && (rec.has_word || rec.has_tok);
    assign o_rec  = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf     <= '0;
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_wline   <= POSITION_BITS'(1);
            r_wcol    <= POSITION_BITS'(1);
            r_line    <= POSITION_BITS'(1);
            r_col     <= POSITION_BITS'(1);
            r_comment <= 1'b0;
            r_halted  <= 1'b0;
        end else if (accept) begin
            r_buf     <= n_buf;
            r_len     <= n_len;
            r_ovf     <= n_ovf;
            r_wline   <= n_wline;
            r_wcol    <= n_wcol;
            r_line    <= n_line;
            r_col     <= n_col;
            r_comment <= n_comment;
            r_halted  <= n_halted;
        end
    end

    a_halt_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (r_len == '0) && !r_ovf)
        else $error("halted with a pending word");

endmodule

// File: rtl/asm_tok_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asm_tok_fifo
// Short register queue of token records between front and back.
// ----------------------------------------------------------------------------
module asm_tok_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  asm_tok_pkg::t_rec i_rec,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output asm_tok_pkg::t_rec o_head
);

    localparam int DEPTH = asm_tok_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    asm_tok_pkg::t_rec r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push)
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            if (do_pop)
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            if (do_push && !do_pop)
                r_cnt <= r_cnt + CNT_W'(1);
            else if (do_pop && !do_push)
                r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("record pushed into full queue");

    a_nonempty_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_rec.has_word || i_rec.has_tok))
        else $error("empty record pushed");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("queue count lost a push");

endmodule

// File: rtl/asm_tok_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asm_tok_back
// Drains queue records onto the result channel, one token per beat; a record
// holding a word and a one-byte token takes two beats.
// ----------------------------------------------------------------------------
module asm_tok_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  asm_tok_pkg::t_rec i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_token_kind,
    output logic [63:0]       o_token_text,
    output logic [3:0]        o_token_length,
    output logic              o_text_overflow,
    output logic [15:0]       o_start_line,
    output logic [15:0]       o_start_column,
    output logic              o_last_of_run
);

    logic r_second;
    logic show_word;
    logic beat;

    assign o_valid   = !i_empty;
    assign beat      = o_valid && !i_stall;
    assign show_word = i_head.has_word && !r_second;
    assign o_pop     = beat && !(show_word && i_head.has_tok);

    always_comb begin
        if (show_word) begin
            o_token_kind    = asm_tok_pkg::KIND_WORD;
            o_token_text    = i_head.word_text;
            o_token_length  = i_head.word_len;
            o_text_overflow = i_head.word_ovf;
            o_start_line    = i_head.word_line;
            o_start_column  = i_head.word_col;
            o_last_of_run   = !i_head.has_tok;
        end else begin
            o_token_kind    = i_head.tok_kind;
            o_token_text    = 64'(i_head.tok_char);
            o_token_length  = 4'd1;
            o_text_overflow = 1'b0;
            o_start_line    = i_head.tok_line;
            o_start_column  = i_head.tok_col;
            o_last_of_run   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_second <= 1'b0;
        else if (beat)
            r_second <= !o_pop;
    end

    a_second_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> o_valid && i_head.has_word && i_head.has_tok)
        else $error("second beat without a two-token record");

endmodule

// File: rtl/assembly_source_tokenizer_unit.sv
`timescale 1ns / 1ps
// Timing: a token is queued when the byte completing it is accepted, then
//   shown from the queue head. A 4-record queue decouples the sides.
// Throughput: one byte per cycle unless stalled; a byte that yields a word
//   and a symbol or newline uses two result beats.
// Reset: synchronous, active low; clears position, word and queue state.
// ----------------------------------------------------------------------------
// assembly_source_tokenizer_unit
// Byte-stream tokenizer for assembly source: words, symbols, newlines and
// illegal characters, each tagged with its starting line and column.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer_unit #(
    parameter int MAX_WORD_BYTES = asm_tok_pkg::MAX_WORD_BYTES_DEF,
    parameter int POSITION_BITS  = asm_tok_pkg::POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_token_kind,
    output logic [63:0] o_token_text,
    output logic [3:0]  o_token_length,
    output logic        o_text_overflow,
    output logic [15:0] o_start_line,
    output logic [15:0] o_start_column,
    output logic        o_last_of_run
);

    logic              push, pop, full, empty;
    asm_tok_pkg::t_rec rec, head;

    asm_tok_front #(
        .MAX_WORD_BYTES (MAX_WORD_BYTES),
        .POSITION_BITS  (POSITION_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_char_in      (i_char_in),
        .i_end_of_input (i_end_of_input),
        .i_full         (full),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_rec          (rec)
    );

    asm_tok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    asm_tok_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_token_kind    (o_token_kind),
        .o_token_text    (o_token_text),
        .o_token_length  (o_token_length),
        .o_text_overflow (o_text_overflow),
        .o_start_line    (o_start_line),
        .o_start_column  (o_start_column),
        .o_last_of_run   (o_last_of_run)
    );

endmodule
